/* sv/cfa_pkg.sv */
package cfa_pkg;

  // payload widths
  localparam int KIND_W   = 1;
  localparam int ID_W     = 8;
  localparam int SIZE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int START_W  = 7;
  localparam int HOLES_W  = 7;
  localparam int USED_W   = 8;

  // item kinds
  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // fit policy codes
  localparam logic POLICY_FIRST = 1'b0;
  localparam logic POLICY_BEST  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD     = 2'd2;

  // datapath operations
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP   = 4'd0;
  localparam logic [OP_W-1:0] OP_CLR   = 4'd1;
  localparam logic [OP_W-1:0] OP_LOAD  = 4'd2;
  localparam logic [OP_W-1:0] OP_FIND  = 4'd3;
  localparam logic [OP_W-1:0] OP_PICK  = 4'd4;
  localparam logic [OP_W-1:0] OP_FILL  = 4'd5;
  localparam logic [OP_W-1:0] OP_RFIND = 4'd6;
  localparam logic [OP_W-1:0] OP_RFREE = 4'd7;
  localparam logic [OP_W-1:0] OP_POST  = 4'd8;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cfa_cmd_t;

  typedef struct packed {
    logic clr_last;   // clearing pass at last unit
    logic bad;        // offered item has owner zero, or is an allocate of size zero
    logic is_rel;     // offered item is a release
    logic scan_end;   // scan pointer sits on the end sentinel
    logic ff_hit;     // first fit found a hole at this unit
    logic pick_ok;    // a hole was chosen
    logic rel_hit;    // current unit belongs to the owner
    logic fill_last;  // last unit of the fill run
  } cfa_stat_t;

endpackage

/* sv/cfa_in_if.sv */
interface cfa_in_if;
  logic                         valid;
  logic                         ready;
  logic [cfa_pkg::KIND_W-1:0]   kind;
  logic [cfa_pkg::ID_W-1:0]     owner_id;
  logic [cfa_pkg::SIZE_W-1:0]   size;

  modport source (output valid, kind, owner_id, size, input ready);
  modport sink   (input valid, kind, owner_id, size, output ready);
endinterface

/* sv/cfa_out_if.sv */
interface cfa_out_if;
  logic                          valid;
  logic                          ready;
  logic [cfa_pkg::STATUS_W-1:0]  status;
  logic [cfa_pkg::START_W-1:0]   start_unit;
  logic [cfa_pkg::HOLES_W-1:0]   hole_count;
  logic [cfa_pkg::USED_W-1:0]    used_units;

  modport source (output valid, status, start_unit, hole_count, used_units, input ready);
  modport sink   (input valid, status, start_unit, hole_count, used_units, output ready);
endinterface

/* sv/cfa_cfg_if.sv */
interface cfa_cfg_if;
  logic valid;
  logic ready;
  logic fit_policy;

  modport source (output valid, fit_policy, input ready);
  modport sink   (input valid, fit_policy, output ready);
endinterface

/* sv/cfa_dp.sv */
module cfa_dp #(
  parameter int MEM_UNITS = 128
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cfa_pkg::cfa_cmd_t              cmd,
  output cfa_pkg::cfa_stat_t             st,
  input  logic [cfa_pkg::KIND_W-1:0]     in_kind,
  input  logic [cfa_pkg::ID_W-1:0]       in_owner_id,
  input  logic [cfa_pkg::SIZE_W-1:0]     in_size,
  input  logic                           cfg_we,
  input  logic                           cfg_fit_policy,
  output logic [cfa_pkg::STATUS_W-1:0]   out_status,
  output logic [cfa_pkg::START_W-1:0]    out_start_unit,
  output logic [cfa_pkg::HOLES_W-1:0]    out_hole_count,
  output logic [cfa_pkg::USED_W-1:0]     out_used_units
);

  localparam int AW   = (MEM_UNITS > 1) ? $clog2(MEM_UNITS) : 1;
  localparam int CW   = $clog2(MEM_UNITS + 1);
  localparam int CMPW = (CW > cfa_pkg::SIZE_W) ? CW : cfa_pkg::SIZE_W;
  localparam logic [CW-1:0] LAST = CW'(MEM_UNITS - 1);
  localparam logic [CW-1:0] ENDP = CW'(MEM_UNITS);

  // unit map
  logic [cfa_pkg::ID_W-1:0] mem [MEM_UNITS];
  logic [cfa_pkg::ID_W-1:0] rd_data_r;
  logic                     we;
  logic                     re;
  logic [AW-1:0]            wa;
  logic [AW-1:0]            ra;
  logic [cfa_pkg::ID_W-1:0] wd;

  logic [CW-1:0]               p_r, p_nxt;
  logic [cfa_pkg::ID_W-1:0]    id_r, id_nxt;
  logic [cfa_pkg::SIZE_W-1:0]  size_r, size_nxt;
  logic [CW-1:0]               run_r, run_nxt;
  logic [CW-1:0]               best_len_r, best_len_nxt;
  logic [AW-1:0]               pick_r, pick_nxt;
  logic                        pick_v_r, pick_v_nxt;
  logic [AW-1:0]               start_r, start_nxt;
  logic                        left_free_r, left_free_nxt;
  logic                        prev_free_r, prev_free_nxt;
  logic [CW-1:0]               freed_r, freed_nxt;
  logic [CW-1:0]               holes_r, holes_nxt;
  logic [CW-1:0]               used_r, used_nxt;
  logic                        fit_policy_r, fit_policy_nxt;
  logic [cfa_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;

  logic [cfa_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [cfa_pkg::START_W-1:0]  out_start_r, out_start_nxt;
  logic [cfa_pkg::HOLES_W-1:0]  out_holes_r, out_holes_nxt;
  logic [cfa_pkg::USED_W-1:0]   out_used_r, out_used_nxt;

  logic          at_end;
  logic          unit_free;
  logic          id_match;
  logic          fits;
  logic          better;
  logic [CW-1:0] hole_start;
  logic [CW:0]   p_inc;
  logic          rd_ok;
  logic          exact;

  logic [AW+cfa_pkg::START_W-1:0] start_w;
  logic [CW+cfa_pkg::HOLES_W-1:0] holes_w;
  logic [CW+cfa_pkg::USED_W-1:0]  used_w;

  assign at_end     = (p_r == ENDP);
  assign unit_free  = !at_end && (rd_data_r == '0);
  assign id_match   = !at_end && (rd_data_r == id_r);
  assign fits       = CMPW'(run_r) >= CMPW'(size_r);
  assign better     = !pick_v_r || (run_r <= best_len_r);
  assign hole_start = p_r - run_r;
  assign p_inc      = (CW+1)'(p_r) + (CW+1)'(1);
  assign rd_ok      = p_inc < (CW+1)'(MEM_UNITS);
  assign exact      = CMPW'(size_r) == CMPW'(best_len_r);

  assign start_w = {{cfa_pkg::START_W{1'b0}}, start_r};
  assign holes_w = {{cfa_pkg::HOLES_W{1'b0}}, holes_r};
  assign used_w  = {{cfa_pkg::USED_W{1'b0}}, used_r};

  assign st.clr_last  = (p_r == LAST);
  assign st.bad       = (in_owner_id == '0) ||
                        ((in_kind == cfa_pkg::KIND_ALLOC) && (in_size == '0));
  assign st.is_rel    = (in_kind == cfa_pkg::KIND_RELEASE);
  assign st.scan_end  = at_end;
  assign st.ff_hit    = !unit_free && fits && (fit_policy_r == cfa_pkg::POLICY_FIRST);
  assign st.pick_ok   = pick_v_r;
  assign st.rel_hit   = id_match;
  assign st.fill_last = (size_r == cfa_pkg::SIZE_W'(1));

  always_comb begin
    p_nxt          = p_r;
    id_nxt         = id_r;
    size_nxt       = size_r;
    run_nxt        = run_r;
    best_len_nxt   = best_len_r;
    pick_nxt       = pick_r;
    pick_v_nxt     = pick_v_r;
    start_nxt      = start_r;
    left_free_nxt  = left_free_r;
    prev_free_nxt  = prev_free_r;
    freed_nxt      = freed_r;
    holes_nxt      = holes_r;
    used_nxt       = used_r;
    res_status_nxt = res_status_r;
    fit_policy_nxt = cfg_we ? cfg_fit_policy : fit_policy_r;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    out_holes_nxt  = out_holes_r;
    out_used_nxt   = out_used_r;
    we             = 1'b0;
    re             = 1'b0;
    wa             = p_r[AW-1:0];
    ra             = p_inc[AW-1:0];
    wd             = '0;

    case (cmd.op)
      cfa_pkg::OP_CLR: begin
        we    = 1'b1;
        p_nxt = (p_r == LAST) ? '0 : p_inc[CW-1:0];
      end
      cfa_pkg::OP_LOAD: begin
        id_nxt         = in_owner_id;
        size_nxt       = in_size;
        p_nxt          = '0;
        run_nxt        = '0;
        pick_v_nxt     = 1'b0;
        prev_free_nxt  = 1'b0;
        freed_nxt      = '0;
        start_nxt      = '0;
        res_status_nxt = st.bad ? cfa_pkg::ST_BAD : cfa_pkg::ST_OK;
        re             = 1'b1;
        ra             = '0;
      end
      cfa_pkg::OP_FIND: begin
        if (unit_free) begin
          run_nxt = run_r + CW'(1);
        end else begin
          // close the hole that ends here, sentinel included
          if (fits && ((fit_policy_r == cfa_pkg::POLICY_FIRST) || better)) begin
            pick_nxt     = hole_start[AW-1:0];
            best_len_nxt = run_r;
            pick_v_nxt   = 1'b1;
          end
          run_nxt = '0;
        end
        if (!at_end) begin
          p_nxt = p_inc[CW-1:0];
          re    = rd_ok;
        end
      end
      cfa_pkg::OP_PICK: begin
        if (pick_v_r) begin
          start_nxt = pick_r;
          p_nxt     = CW'(pick_r);
          used_nxt  = used_r + CW'(size_r);
          if (exact) begin
            holes_nxt = holes_r - CW'(1);
          end
        end else begin
          res_status_nxt = cfa_pkg::ST_NOSPACE;
        end
      end
      cfa_pkg::OP_FILL: begin
        we       = 1'b1;
        wd       = id_r;
        p_nxt    = p_inc[CW-1:0];
        size_nxt = size_r - cfa_pkg::SIZE_W'(1);
      end
      cfa_pkg::OP_RFIND: begin
        if (at_end) begin
          res_status_nxt = cfa_pkg::ST_BAD;
        end else if (id_match) begin
          we            = 1'b1;
          start_nxt     = p_r[AW-1:0];
          left_free_nxt = prev_free_r;
          freed_nxt     = CW'(1);
          p_nxt         = p_inc[CW-1:0];
          re            = rd_ok;
        end else begin
          prev_free_nxt = (rd_data_r == '0);
          p_nxt         = p_inc[CW-1:0];
          re            = rd_ok;
        end
      end
      cfa_pkg::OP_RFREE: begin
        if (id_match) begin
          we        = 1'b1;
          freed_nxt = freed_r + CW'(1);
          p_nxt     = p_inc[CW-1:0];
          re        = rd_ok;
        end else begin
          // freed run merges with free neighbors on either side
          holes_nxt = holes_r + CW'(1) - CW'(left_free_r) - CW'(unit_free);
          used_nxt  = used_r - freed_r;
        end
      end
      cfa_pkg::OP_POST: begin
        out_status_nxt = res_status_r;
        out_start_nxt  = (res_status_r == cfa_pkg::ST_OK) ?
                         start_w[cfa_pkg::START_W-1:0] : '0;
        out_holes_nxt  = holes_w[cfa_pkg::HOLES_W-1:0];
        out_used_nxt   = used_w[cfa_pkg::USED_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data_r <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r          <= '0;
      pick_v_r     <= 1'b0;
      holes_r      <= CW'(1);
      used_r       <= '0;
      fit_policy_r <= cfa_pkg::POLICY_BEST;
      res_status_r <= cfa_pkg::ST_OK;
    end else begin
      p_r          <= p_nxt;
      pick_v_r     <= pick_v_nxt;
      holes_r      <= holes_nxt;
      used_r       <= used_nxt;
      fit_policy_r <= fit_policy_nxt;
      res_status_r <= res_status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r          <= id_nxt;
    size_r        <= size_nxt;
    run_r         <= run_nxt;
    best_len_r    <= best_len_nxt;
    pick_r        <= pick_nxt;
    start_r       <= start_nxt;
    left_free_r   <= left_free_nxt;
    prev_free_r   <= prev_free_nxt;
    freed_r       <= freed_nxt;
    out_status_r  <= out_status_nxt;
    out_start_r   <= out_start_nxt;
    out_holes_r   <= out_holes_nxt;
    out_used_r    <= out_used_nxt;
  end

  assign out_status     = out_status_r;
  assign out_start_unit = out_start_r;
  assign out_hole_count = out_holes_r;
  assign out_used_units = out_used_r;

  a_holes_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((CW+1)'(holes_r) << 1) <= (CW+1)'(MEM_UNITS + 1))
    else $error("hole count exceeds map capacity");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= ENDP)
    else $error("used count exceeds map size");

  a_fill_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == cfa_pkg::OP_FILL) |-> (p_r < ENDP) && (size_r != '0))
    else $error("fill runs past the map");

endmodule

/* sv/cfa_ctrl.sv */
module cfa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  cfa_pkg::cfa_stat_t  st,
  output cfa_pkg::cfa_cmd_t   cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FIND  = 3'd2;
  localparam logic [2:0] S_PICK  = 3'd3;
  localparam logic [2:0] S_FILL  = 3'd4;
  localparam logic [2:0] S_RFIND = 3'd5;
  localparam logic [2:0] S_RFREE = 3'd6;
  localparam logic [2:0] S_POST  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire;
  logic       post_ok;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign post_ok  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = cfa_pkg::OP_NOP;
    case (state_r)
      S_CLEAR: begin
        cmd.op = cfa_pkg::OP_CLR;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd.op = cfa_pkg::OP_LOAD;
          if (st.bad) begin
            state_nxt = S_POST;
          end else if (st.is_rel) begin
            state_nxt = S_RFIND;
          end else begin
            state_nxt = S_FIND;
          end
        end
      end
      S_FIND: begin
        cmd.op = cfa_pkg::OP_FIND;
        if (st.ff_hit || st.scan_end) begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        cmd.op    = cfa_pkg::OP_PICK;
        state_nxt = st.pick_ok ? S_FILL : S_POST;
      end
      S_FILL: begin
        cmd.op = cfa_pkg::OP_FILL;
        if (st.fill_last) begin
          state_nxt = S_POST;
        end
      end
      S_RFIND: begin
        cmd.op = cfa_pkg::OP_RFIND;
        if (st.scan_end) begin
          state_nxt = S_POST;
        end else if (st.rel_hit) begin
          state_nxt = S_RFREE;
        end
      end
      S_RFREE: begin
        cmd.op = cfa_pkg::OP_RFREE;
        if (!st.rel_hit) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        if (post_ok) begin
          cmd.op        = cfa_pkg::OP_POST;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_fire_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("accepted beat did not start an operation");

  a_result_from_post: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_POST))
    else $error("result raised outside post");

  a_bad_skips_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && st.bad) |=> (state_r == S_POST))
    else $error("rejected item entered a scan");

endmodule

/* sv/contiguous_fit_allocator_core.sv */
// channel   dir  handshake     payload
// in_ch     in   valid/ready   kind, owner_id, size
// out_ch    out  valid/ready   status, start_unit, hole_count, used_units
// cfg_ch    in   valid/ready   fit_policy (always ready)
//
// one item at a time; allocate scans the unit map for a hole and then fills it, release
// scans the map for the owner's run and frees it
// after reset a clearing pass zeroes every unit of the map; in_ch is held off until it
// ends, cfg_ch beats are taken throughout
// a finished result sits in the output register while the next item is taken;
// a stalled out_ch only holds the block when a second result is ready
module contiguous_fit_allocator_core #(
  parameter int MEM_UNITS = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  cfa_in_if.sink     in_ch,
  cfa_out_if.source  out_ch,
  cfa_cfg_if.sink    cfg_ch
);

  cfa_pkg::cfa_cmd_t  cmd;
  cfa_pkg::cfa_stat_t st;

  // register write always lands
  assign cfg_ch.ready = 1'b1;

  // sequencer: clear pass, scan, fill, release, result handoff
  cfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // unit map, hole search, running counts and result register
  cfa_dp #(
    .MEM_UNITS (MEM_UNITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_kind        (in_ch.kind),
    .in_owner_id    (in_ch.owner_id),
    .in_size        (in_ch.size),
    .cfg_we         (cfg_ch.valid),
    .cfg_fit_policy (cfg_ch.fit_policy),
    .out_status     (out_ch.status),
    .out_start_unit (out_ch.start_unit),
    .out_hole_count (out_ch.hole_count),
    .out_used_units (out_ch.used_units)
  );

endmodule
